// ===== rtl/ibwf_pkg.sv =====
// Shared types, codes and sizes for the IPv4 ban table filter.
`default_nettype none

package ibwf_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [7:0] OCTET_WILDCARD = 8'hFF;

	// Command codes
	localparam logic [1:0] CMD_QUERY  = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Status codes
	localparam logic [1:0] STATUS_NOT_BANNED = 2'd0;
	localparam logic [1:0] STATUS_PERMANENT  = 2'd1;
	localparam logic [1:0] STATUS_TIME_LEFT  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	// One stored ban entry
	typedef struct packed {
		logic [31:0] pattern;
		logic [31:0] expiry;
	} entry_t;

	// Verdict of the compare unit on one entry
	typedef struct packed {
		logic hit_pattern;
		logic permanent;
		logic time_left;
	} match_res_t;

endpackage

`default_nettype wire

// ===== rtl/ibwf_mem.sv =====
// Entry store: pattern and expiry per slot, one write port, one registered read port.
`default_nettype none

module ibwf_mem (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire ibwf_pkg::idx_t  wr_idx,
	input  wire ibwf_pkg::entry_t wr_data,
	input  wire logic            rd_en,
	input  wire ibwf_pkg::idx_t  rd_idx,
	output ibwf_pkg::entry_t     rd_data
);
	import ibwf_pkg::*;

	entry_t mem_q [TABLE_ENTRIES];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/ibwf_match.sv =====
// Shared compare unit: wildcard octet match and expiry classification of one entry.
`default_nettype none

module ibwf_match (
	input  wire ibwf_pkg::entry_t  entry,
	input  wire logic [31:0]       address,
	input  wire logic [31:0]       current_time,
	output ibwf_pkg::match_res_t   res
);
	import ibwf_pkg::*;

	logic [3:0] octet_ok;

	// each octet matches exactly or through the wildcard
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			octet_ok[k] = (entry.pattern[8*k +: 8] == address[8*k +: 8]) ||
				(entry.pattern[8*k +: 8] == OCTET_WILDCARD);
		end
	end

	// expiry of zero is permanent; later than now is a running ban
	always_comb begin
		res.hit_pattern = &octet_ok;
		res.permanent   = (entry.expiry == 32'd0);
		res.time_left   = (entry.expiry > current_time);
	end

endmodule

`default_nettype wire

// ===== rtl/ip_ban_wildcard_filter.sv =====
// IPv4 ban table with octet wildcards: sequencer, valid bits and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | command, address, ban_expiry, current_time
//  out     | out_valid / out_ready| status, expired_removed, table_full
//
// Query: one entry compared per cycle through a registered memory read; the scan
//   ends at the first valid slot that matches, or after the last slot on a miss.
// Insert: one valid bit checked per cycle; the entry goes into the first free slot,
//   or table_full is reported when none is free. Clear and unused command finish directly.
// Reset clears all valid bits at once; no clearing pass is needed.
// One item at a time: in_ready is high only while the sequencer is idle; a result
//   held in the output register stalls the sequencer only at its final step.
`default_nettype none

module ip_ban_wildcard_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] address,
	input  wire logic [31:0] ban_expiry,
	input  wire logic [31:0] current_time,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             expired_removed,
	output logic             table_full
);
	import ibwf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_QRY  = 2'd1;
	localparam logic [1:0] ST_INS  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam idx_t LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [1:0]               state_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	idx_t                     scan_idx_q;
	logic                     issue_done_q;
	logic                     vld_s1;
	idx_t                     idx_s1;
	logic                     out_valid_q;

	logic [31:0] addr_q;
	logic [31:0] exp_q;
	logic [31:0] now_q;
	logic [1:0]  res_status_q;
	logic        res_removed_q;
	logic        res_full_q;
	logic [1:0]  status_q;
	logic        removed_q;
	logic        full_q;

	logic       accept;
	logic       issue;
	logic       scan_last;
	logic       q_hit;
	logic       q_miss_end;
	logic       ins_free;
	logic       ins_full;
	logic       fin_load;
	entry_t     rd_entry;
	entry_t     wr_entry;
	match_res_t mres;

	// control decodes
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign scan_last  = (scan_idx_q == LAST_IDX);
	assign issue      = (state_q == ST_QRY) && !issue_done_q;
	assign q_hit      = (state_q == ST_QRY) && vld_s1 && valid_q[idx_s1] && mres.hit_pattern;
	assign q_miss_end = (state_q == ST_QRY) && vld_s1 && !q_hit && (idx_s1 == LAST_IDX);
	assign ins_free   = (state_q == ST_INS) && !valid_q[scan_idx_q];
	assign ins_full   = (state_q == ST_INS) && valid_q[scan_idx_q] && scan_last;
	assign fin_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign wr_entry.pattern = addr_q;
	assign wr_entry.expiry  = exp_q;

	ibwf_mem u_mem (
		.clk     (clk),
		.wr_en   (ins_free),
		.wr_idx  (scan_idx_q),
		.wr_data (wr_entry),
		.rd_en   (issue),
		.rd_idx  (scan_idx_q),
		.rd_data (rd_entry)
	);

	ibwf_match u_match (
		.entry        (rd_entry),
		.address      (addr_q),
		.current_time (now_q),
		.res          (mres)
	);

	// sequencer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			scan_idx_q   <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// a hit drops the read already in flight
			vld_s1 <= issue && !q_hit;
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					scan_idx_q   <= '0;
					issue_done_q <= 1'b0;
					if (accept) begin
						unique case (command)
							CMD_QUERY:  state_q <= ST_QRY;
							CMD_INSERT: state_q <= ST_INS;
							CMD_CLEAR: begin
								valid_q <= '0;
								state_q <= ST_FIN;
							end
							default:    state_q <= ST_FIN;
						endcase
					end
				end
				ST_QRY: begin
					if (issue) begin
						if (scan_last) begin
							issue_done_q <= 1'b1;
						end else begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end
					if (q_hit) begin
						state_q <= ST_FIN;
						// stale entry is dropped from the table
						if (!mres.permanent && !mres.time_left) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end else if (q_miss_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_INS: begin
					if (ins_free) begin
						valid_q[scan_idx_q] <= 1'b1;
						state_q             <= ST_FIN;
					end else if (ins_full) begin
						state_q <= ST_FIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, pipeline index, pending result and output data
	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (accept) begin
			addr_q        <= address;
			exp_q         <= ban_expiry;
			now_q         <= current_time;
			res_status_q  <= STATUS_NOT_BANNED;
			res_removed_q <= 1'b0;
			res_full_q    <= 1'b0;
		end
		if (q_hit) begin
			priority if (mres.permanent) begin
				res_status_q <= STATUS_PERMANENT;
			end else if (mres.time_left) begin
				res_status_q <= STATUS_TIME_LEFT;
			end else begin
				res_removed_q <= 1'b1;
			end
		end
		if (ins_full) begin
			res_full_q <= 1'b1;
		end
		if (fin_load) begin
			status_q  <= res_status_q;
			removed_q <= res_removed_q;
			full_q    <= res_full_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign expired_removed = removed_q;
	assign table_full      = full_q;

`ifndef SYNTHESIS
	// a removed ban always reports not banned
	a_removed_not_banned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired_removed |-> status == STATUS_NOT_BANNED)
		else $error("expired_removed with a ban status");

	// full and removed come from different commands
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !expired_removed && status == STATUS_NOT_BANNED)
		else $error("table_full together with a query verdict");

	// a clear empties every slot at once
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_CLEAR |=> valid_q == '0)
		else $error("valid bits left after clear");

	// compare stage only runs while scanning for a query
	a_s1_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == ST_QRY)
		else $error("compare stage active outside a query");

	// an insert that finds a free slot makes it valid
	a_ins_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ins_free |=> valid_q[$past(scan_idx_q)])
		else $error("inserted slot not valid");
`endif

endmodule

`default_nettype wire
